// File: rtl/core/spe_pkg.sv
// ============================================================================
// spe_pkg: shared types and constants of the sparse polynomial evaluator
// Holds the request and result structs, fixed-point limits and the
// command and status groups that pass between the controller and datapath.
// ============================================================================
package spe_pkg;

    localparam int MAX_EXP_BITS = 5;

    localparam int X_W     = 24;
    localparam int COEF_W  = 32;
    localparam int EXP_W   = 5;
    localparam int VAL_W   = 48;
    localparam int FRAC_W  = 16;
    localparam int CHUNK_W = 32;
    localparam int ACC_W   = 2 * VAL_W + 1;

    localparam logic signed [VAL_W-1:0] Q_ONE   = VAL_W'(1) << FRAC_W;
    localparam logic signed [VAL_W-1:0] SUM_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] SUM_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic signed [X_W-1:0]    x_value;
        logic signed [COEF_W-1:0] coef;
        logic [EXP_W-1:0]         exponent;
        logic                     last_term;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] poly_value;
        logic                    overflow;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_BIT,
        S_PMUL,
        S_SQR,
        S_BMUL,
        S_TERM,
        S_TMUL,
        S_ACC,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_PB,
        MUL_BB,
        MUL_CP
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     take_p;
        logic     take_b;
        logic     take_term;
        logic     shift_e;
        logic     accumulate;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic coef_zero;
        logic e_zero;
        logic e_bit0;
        logic e_more;
        logic last;
        logic mul_done;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/core/spe_qmul.sv
// ============================================================================
// spe_qmul: multi-cycle Q.16 multiplier with rounding and saturation
// Forms the exact magnitude product from four 32x32 partial products on one
// multiplier, rounds half away from zero and saturates to 48 bits.
// ============================================================================
module spe_qmul
    import spe_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [VAL_W-1:0] a,
    input  logic signed [VAL_W-1:0] b,
    output logic                    done,
    output logic signed [VAL_W-1:0] res,
    output logic                    ovf
);

    localparam logic [2:0] LAST_PP   = 3'd3;
    localparam logic [2:0] LAST_STEP = 3'd5;
    localparam int         HI_W      = VAL_W - CHUNK_W;

    logic                busy_reg;
    logic [2:0]          step_reg;
    logic                neg_reg;
    logic [VAL_W-1:0]    ma_reg;
    logic [VAL_W-1:0]    mb_reg;
    logic [2*CHUNK_W-1:0] pp_reg;
    logic [1:0]          sh_reg;
    logic [ACC_W-1:0]    acc_reg;

    logic [VAL_W-1:0]     a_mag;
    logic [VAL_W-1:0]     b_mag;
    logic [CHUNK_W-1:0]   a_chunk;
    logic [CHUNK_W-1:0]   b_chunk;
    logic [2*CHUNK_W-1:0] prod;
    logic [ACC_W-1:0]     addend;
    logic [VAL_W-1:0]     q48;
    logic [VAL_W-1:0]     limit;
    logic                 big;

    assign a_mag = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
    assign b_mag = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);

    // Step bit 0 picks the high part of a, bit 1 the high part of b.
    assign a_chunk = step_reg[0] ? {{(CHUNK_W-HI_W){1'b0}}, ma_reg[VAL_W-1:CHUNK_W]}
                                 : ma_reg[CHUNK_W-1:0];
    assign b_chunk = step_reg[1] ? {{(CHUNK_W-HI_W){1'b0}}, mb_reg[VAL_W-1:CHUNK_W]}
                                 : mb_reg[CHUNK_W-1:0];
    assign prod    = a_chunk * b_chunk;

    always_comb
    begin
        case (sh_reg)
            2'd1:    addend = ACC_W'(pp_reg) << CHUNK_W;
            2'd2:    addend = ACC_W'(pp_reg) << (2 * CHUNK_W);
            default: addend = ACC_W'(pp_reg);
        endcase
    end

    // The accumulator starts at half an LSB of the result, so the slice
    // above the fraction bits is already rounded.
    assign q48   = acc_reg[VAL_W+FRAC_W-1:FRAC_W];
    assign limit = neg_reg ? VAL_W'(SUM_MIN) : VAL_W'(SUM_MAX);
    assign big   = (|acc_reg[ACC_W-1:VAL_W+FRAC_W]) || (q48 > limit);

    assign done = busy_reg && (step_reg == LAST_STEP);
    assign ovf  = big;
    assign res  = big ? (neg_reg ? SUM_MIN : SUM_MAX)
                      : (neg_reg ? VAL_W'(-q48) : VAL_W'(q48));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == LAST_STEP)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= a[VAL_W-1] ^ b[VAL_W-1];
            ma_reg  <= a_mag;
            mb_reg  <= b_mag;
            acc_reg <= ACC_W'(1) << (FRAC_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg <= LAST_PP)
            begin
                pp_reg <= prod;
                sh_reg <= 2'(step_reg[0]) + 2'(step_reg[1]);
            end
            if (step_reg != 3'd0 && step_reg <= LAST_PP + 3'd1)
                acc_reg <= acc_reg + addend;
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy_reg)
        else $error("multiplier still busy after done");

endmodule

// File: rtl/core/spe_datapath.sv
// ============================================================================
// spe_datapath: registers and arithmetic of the polynomial evaluator
// Holds the latched point, power, base, term and saturating accumulator,
// and the output register of the result channel.
// ============================================================================
module spe_datapath
    import spe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result
);

    logic signed [X_W-1:0]    held_x_reg;
    logic                     first_reg;
    logic signed [VAL_W-1:0]  sum_reg;
    logic                     sat_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic [MAX_EXP_BITS-1:0]  e_reg;
    logic                     last_reg;
    logic signed [VAL_W-1:0]  p_reg;
    logic signed [VAL_W-1:0]  b_reg;
    logic                     povf_reg;
    logic signed [VAL_W-1:0]  term_reg;
    logic                     tovf_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;

    logic [EXP_W:0]          exp_ext;
    logic signed [X_W-1:0]   x_use;
    logic signed [VAL_W-1:0] mul_a;
    logic signed [VAL_W-1:0] mul_b;
    logic                    mul_done;
    logic signed [VAL_W-1:0] mul_res;
    logic                    mul_ovf;
    logic signed [VAL_W:0]   sum_wide;
    logic                    add_ovf;
    logic signed [VAL_W-1:0] sum_sat;

    assign exp_ext = {1'b0, item.exponent};
    assign x_use   = first_reg ? item.x_value : held_x_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_PB:  begin mul_a = p_reg; mul_b = b_reg; end
            MUL_BB:  begin mul_a = b_reg; mul_b = b_reg; end
            MUL_CP:
            begin
                mul_a = {{(VAL_W-COEF_W){coef_reg[COEF_W-1]}}, coef_reg};
                mul_b = p_reg;
            end
            default: begin mul_a = p_reg; mul_b = b_reg; end
        endcase
    end

    spe_qmul u_qmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res),
        .ovf   (mul_ovf)
    );

    assign sum_wide = {sum_reg[VAL_W-1], sum_reg} + {term_reg[VAL_W-1], term_reg};
    assign add_ovf  = sum_wide[VAL_W] != sum_wide[VAL_W-1];
    assign sum_sat  = add_ovf ? (sum_wide[VAL_W] ? SUM_MIN : SUM_MAX)
                              : sum_wide[VAL_W-1:0];

    always_comb
    begin
        status.coef_zero = (coef_reg == '0);
        status.e_zero    = (e_reg == '0);
        status.e_bit0    = e_reg[0];
        status.e_more    = ((e_reg >> 1) != '0);
        status.last      = last_reg;
        status.mul_done  = mul_done;
        status.out_free  = !result_valid_reg || !result_stall;
    end

    // Polynomial-level state: sum and overflow flag clear, and x re-arms, when a result is emitted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg <= '0;
            first_reg  <= 1'b1;
            sum_reg    <= '0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                held_x_reg <= x_use;
                first_reg  <= 1'b0;
            end
            if (cmd.accumulate)
            begin
                sum_reg <= sum_sat;
                sat_reg <= sat_reg | povf_reg | tovf_reg | add_ovf;
            end
            if (cmd.emit)
            begin
                sum_reg   <= '0;
                sat_reg   <= 1'b0;
                first_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            coef_reg <= item.coef;
            e_reg    <= exp_ext[MAX_EXP_BITS-1:0];
            last_reg <= item.last_term;
            p_reg    <= Q_ONE;
            b_reg    <= {{(VAL_W-X_W){x_use[X_W-1]}}, x_use};
            povf_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_p)
            begin
                p_reg    <= mul_res;
                povf_reg <= povf_reg | mul_ovf;
            end
            if (cmd.take_b)
            begin
                b_reg    <= mul_res;
                povf_reg <= povf_reg | mul_ovf;
            end
            if (cmd.shift_e)
                e_reg <= e_reg >> 1;
        end
        if (cmd.take_term)
        begin
            term_reg <= mul_res;
            tovf_reg <= mul_ovf;
        end
        if (cmd.emit)
        begin
            result_reg.poly_value <= sum_reg;
            result_reg.overflow   <= sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.emit)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!result_valid_reg || !result_stall))
        else $error("pending result overwritten");

    a_take_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_p || cmd.take_b || cmd.take_term) |-> mul_done)
        else $error("multiplier result taken before it was ready");

endmodule

// File: rtl/core/spe_ctrl.sv
// ============================================================================
// spe_ctrl: sequencing controller of the polynomial evaluator
// Walks the exponent bits least significant first, issuing power and
// squaring multiplies, then the coefficient multiply and accumulate, emitting on the last term.
// ============================================================================
module spe_ctrl
    import spe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_PB;
        item_stall = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                // A zero coefficient contributes nothing, not even overflow.
                if (status.coef_zero)
                    state_next = S_DONE;
                else if (status.e_zero)
                    state_next = S_TERM;
                else
                    state_next = S_BIT;
            end
            S_BIT:
            begin
                if (status.e_bit0)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_PB;
                    state_next    = S_PMUL;
                end
                else
                    state_next = S_SQR;
            end
            S_PMUL:
            begin
                cmd.mul_sel = MUL_PB;
                if (status.mul_done)
                begin
                    cmd.take_p = 1'b1;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                // The base is only squared while higher exponent bits remain.
                if (status.e_more)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_BB;
                    state_next    = S_BMUL;
                end
                else
                    state_next = S_TERM;
            end
            S_BMUL:
            begin
                cmd.mul_sel = MUL_BB;
                if (status.mul_done)
                begin
                    cmd.take_b  = 1'b1;
                    cmd.shift_e = 1'b1;
                    state_next  = S_BIT;
                end
            end
            S_TERM:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_CP;
                state_next    = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.mul_sel = MUL_CP;
                if (status.mul_done)
                begin
                    cmd.take_term = 1'b1;
                    state_next    = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!status.last)
                    state_next = S_IDLE;
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// File: rtl/core/sparse_polynomial_evaluator_unit.sv
// ============================================================================
// sparse_polynomial_evaluator_unit: sparse polynomial evaluator, top level
// Sums coef * x^exponent over a stream of monomials in signed Q.16 fixed
// point with saturation, emitting one result on each last monomial.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------
//   item     | item_valid / item_stall   | x_value, coef, exponent, last_term
//   result   | result_valid / result_stall | poly_value, overflow
//
// One monomial is processed at a time. A zero coefficient needs no multiply,
// a zero exponent only the coefficient multiply; every multiply runs on the
// shared 32x32 unit, and exponent 31 needs five power and four squaring
// multiplies plus the coefficient multiply.
// Reset clears the accumulator and overflow flag and arms latching of x.
// A result waits in the output register while the next request is taken;
// only a second result behind a stalled one holds the sequencer.
// ============================================================================
module sparse_polynomial_evaluator_unit
    import spe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    spe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    spe_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: dv/sparse_polynomial_evaluator_unit_test.sv
// ============================================================================
// sparse_polynomial_evaluator_unit_test: testbench of the polynomial evaluator
// Streams monomials into the block and predicts every sum in Q.16 fixed
// point with rounding and saturation. Each returned sum and overflow flag is
// checked against the oldest prediction. The stimulus covers the special
// terms, the field extremes, random polynomials, a long result hold-off
// and pauses that let the block drain. Both sides insert random gaps.
// ============================================================================
module sparse_polynomial_evaluator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spe_pkg::*;

    localparam int CLK_HALF         = 2;
    localparam int RESET_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int SETTLE_CYCLES    = 100;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS     = 1500;

    localparam logic signed [X_W-1:0]    X_MAX    = {1'b0, {(X_W-1){1'b1}}};
    localparam logic signed [X_W-1:0]    X_MIN    = {1'b1, {(X_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_ONE = 1 << FRAC_W;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    // Evaluator state as the block should hold it.
    logic signed [X_W-1:0]   eval_x;
    logic signed [VAL_W-1:0] eval_sum;
    logic                    awaiting_x;
    logic                    eval_sat;
    result_t                 pending_sums[$];

    int sender_gap_max;
    int receiver_gap_max;
    int receiver_hold_cycles;
    int fault_count;
    int idle_cycles;

    sparse_polynomial_evaluator_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Exact Q.16 product, rounded half away from zero, saturated to 48 bits.
    function automatic logic signed [VAL_W-1:0] q16_mul(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b,
                                                        inout logic sat);
        logic             neg;
        logic [VAL_W-1:0] ua;
        logic [VAL_W-1:0] ub;
        logic [95:0]      prod;
        logic [95:0]      q;
        logic [95:0]      limit;
        neg   = a[VAL_W-1] ^ b[VAL_W-1];
        ua    = a[VAL_W-1] ? -a : a;
        ub    = b[VAL_W-1] ? -b : b;
        prod  = 96'(ua) * 96'(ub);
        q     = (prod >> FRAC_W) + prod[FRAC_W-1];
        limit = neg ? (96'(1) << (VAL_W - 1)) : ((96'(1) << (VAL_W - 1)) - 1);
        if (q > limit)
        begin
            sat = 1'b1;
            return neg ? SUM_MIN : SUM_MAX;
        end
        return neg ? -q[VAL_W-1:0] : q[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_accumulate(input logic signed [VAL_W-1:0] a,
                                                               input logic signed [VAL_W-1:0] b,
                                                               inout logic sat);
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
        begin
            sat = 1'b1;
            return s[VAL_W] ? SUM_MIN : SUM_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic void predict_monomial(input item_t req);
        logic signed [VAL_W-1:0] pw;
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] term;
        logic [EXP_W-1:0]        e;
        logic                    pw_sat;
        logic                    term_sat;
        result_t                 sum_out;
        if (awaiting_x)
        begin
            eval_x     = req.x_value;
            awaiting_x = 1'b0;
        end
        // A zero coefficient contributes nothing, even when the power saturates.
        if (req.coef != 0)
        begin
            pw       = Q_ONE;
            base     = eval_x;
            pw_sat   = 1'b0;
            term_sat = 1'b0;
            e        = req.exponent;
            for (int i = 0; i < MAX_EXP_BITS; i++)
            begin
                if (e[i])
                    pw = q16_mul(pw, base, pw_sat);
                // The base is only squared while higher exponent bits remain.
                if ((e >> (i + 1)) != 0)
                    base = q16_mul(base, base, pw_sat);
            end
            term = q16_mul(req.coef, pw, term_sat);
            if (pw_sat || term_sat)
                eval_sat = 1'b1;
            eval_sum = sat_accumulate(eval_sum, term, eval_sat);
        end
        if (req.last_term)
        begin
            sum_out.poly_value = eval_sum;
            sum_out.overflow   = eval_sat;
            pending_sums.push_back(sum_out);
            eval_sum   = '0;
            eval_sat   = 1'b0;
            awaiting_x = 1'b1;
        end
    endfunction

    function automatic item_t make_request(input logic signed [X_W-1:0] x,
                                           input logic signed [COEF_W-1:0] c,
                                           input int unsigned ex, input logic last);
        item_t req;
        req.x_value   = x;
        req.coef      = c;
        req.exponent  = EXP_W'(ex);
        req.last_term = last;
        return req;
    endfunction

    function automatic logic signed [X_W-1:0] draw_x();
        case ($urandom_range(0, 3))
            0: return X_W'($urandom);
            1: return X_W'(int'($urandom_range(0, 262144)) - 131072);
            2: return X_W'(int'($urandom_range(0, 8192)) - 4096
                           + ($urandom_range(0, 1) ? 65536 : -65536));
            default: return X_W'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] draw_coef();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return COEF_W'($urandom);
            2: return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            3: return COEF_W'(int'($urandom_range(0, 524288)) - 262144);
            default: return COEF_W'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic int idle_span();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 4;
            default: return 16;
        endcase
    endfunction

    // Offers one request after a random gap and holds it until it is taken.
    task automatic send_request(input item_t req);
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        do @(posedge clk); while (item_stall);
        predict_monomial(req);
    endtask

    task automatic send_random_polynomial(output int terms);
        int    n;
        item_t req;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        for (int t = 0; t < n; t++)
        begin
            // x on later terms must be ignored, so it is left fully random there.
            req.x_value   = (t == 0) ? draw_x() : X_W'($urandom);
            req.coef      = draw_coef();
            req.exponent  = EXP_W'($urandom_range(0, 31));
            req.last_term = (t == n - 1);
            send_request(req);
        end
        terms = n;
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_special_terms();
        sender_gap_max   = 16;
        receiver_gap_max = 16;
        // Zero exponent gives the coefficient exactly.
        send_request(make_request(X_W'(12345), 32'sh0003_8000, 0, 1'b1));
        // Zero coefficient with a saturating power must not flag overflow.
        send_request(make_request(X_MAX, '0, 31, 1'b1));
        // Exponent one never squares the base, so a large x stays clean.
        send_request(make_request(X_MAX, COEF_ONE, 1, 1'b1));
        send_request(make_request(X_MIN, -COEF_ONE, 1, 1'b1));
        // x is taken from the first term only.
        send_request(make_request(X_W'(131072), COEF_ONE, 2, 1'b0));
        send_request(make_request(X_MAX, COEF_ONE, 3, 1'b0));
        send_request(make_request(X_MIN, 32'sh0000_8000, 0, 1'b1));
        // A saturated polynomial, then a fresh one that must start clean.
        send_request(make_request(X_MAX, COEF_ONE, 31, 1'b1));
        send_request(make_request(X_W'(-98304), 32'sh0002_0000, 3, 1'b1));
        // Squares that round up from just above half an LSB, for x of both signs.
        send_request(make_request(X_W'(182), COEF_ONE, 2, 1'b1));
        send_request(make_request(X_W'(-182), COEF_ONE, 3, 1'b1));
        pause_until_drained();
    endtask

    task automatic test_field_extremes();
        sender_gap_max   = 0;
        receiver_gap_max = 0;
        send_request(make_request('0, COEF_MAX, 0, 1'b1));
        send_request(make_request('0, COEF_MIN, 31, 1'b1));
        send_request(make_request(X_MIN, COEF_MIN, 31, 1'b1));
        send_request(make_request(X_MAX, COEF_MAX, 16, 1'b1));
        // Five large terms drive the sum into saturation, up and then down.
        for (int k = 0; k < 5; k++)
            send_request(make_request(X_MAX, COEF_MAX, 2, k == 4));
        for (int k = 0; k < 5; k++)
            send_request(make_request(X_MAX, COEF_MIN, 2, k == 4));
        pause_until_drained();
    endtask

    task automatic test_random_polynomials(input int target);
        int sent;
        int terms;
        int polys;
        sent  = 0;
        polys = 0;
        while (sent < target)
        begin
            if (polys % 40 == 0)
            begin
                sender_gap_max   = idle_span();
                receiver_gap_max = idle_span();
            end
            send_random_polynomial(terms);
            sent  += terms;
            polys += 1;
        end
        pause_until_drained();
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the block must fill up and stall its input.
    task automatic test_result_backpressure();
        sender_gap_max       = 0;
        receiver_gap_max     = 0;
        receiver_hold_cycles = LONG_HOLD_CYCLES;
        for (int k = 0; k < 30; k++)
            send_request(make_request(draw_x(), draw_coef(), $urandom_range(0, 3), 1'b1));
        pause_until_drained();
    endtask

    task automatic test_drain_pauses();
        int terms;
        sender_gap_max   = 16;
        receiver_gap_max = 16;
        for (int k = 0; k < 12; k++)
        begin
            send_random_polynomial(terms);
            pause_until_drained();
        end
    endtask

    initial
    begin : result_receiver
        int wait_cycles;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            wait_cycles          = $urandom_range(0, receiver_gap_max) + receiver_hold_cycles;
            receiver_hold_cycles = 0;
            if (wait_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual poly_value %0d overflow %0b",
                         $time, result.poly_value, result.overflow);
                fault_count++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (result.poly_value !== want.poly_value)
                begin
                    $display("%0t: poly_value expected %0d actual %0d",
                             $time, want.poly_value, result.poly_value);
                    fault_count++;
                end
                if (result.overflow !== want.overflow)
                begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want.overflow, result.overflow);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        item_valid           = 1'b0;
        item                 = '0;
        sender_gap_max       = 0;
        receiver_gap_max     = 0;
        receiver_hold_cycles = 0;
        fault_count          = 0;
        idle_cycles          = 0;
        eval_x               = '0;
        eval_sum             = '0;
        awaiting_x           = 1'b1;
        eval_sat             = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_special_terms();
        test_field_extremes();
        test_random_polynomials(RANDOM_ITEMS / 2);
        test_result_backpressure();
        test_drain_pauses();
        test_random_polynomials(RANDOM_ITEMS / 2);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
